// ===== design/itrd_pkg.sv =====
// Package for the integer to radix digits unit: constants, types, helpers.
// No dependencies.
`timescale 1ns / 1ps
package itrd_pkg;
    localparam int WORD_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [6:0] CHAR_ZERO = 7'd48;
    localparam logic [6:0] CHAR_LETTER_A = 7'd65;
    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [5:0] DECIMAL_DIGITS = 6'd10;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SIGN, ST_DIV, ST_STORE, ST_EMIT
    } back_state_t;

    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] c;
        if (d < DECIMAL_DIGITS) c = CHAR_ZERO + {1'b0, d};
        else c = CHAR_LETTER_A + {1'b0, d - DECIMAL_DIGITS};
        return c;
    endfunction
endpackage

// ===== design/itrd_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module itrd_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// ===== design/itrd_front.sv =====
// Front: accept values, split into sign and magnitude, queue them.
// Depends on itrd_pkg.
`timescale 1ns / 1ps
module itrd_front #(
    parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_value,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic [WORD_BITS-1:0] q_mag,
    output logic                 q_neg
);
    localparam int D = itrd_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);
    logic [WORD_BITS-1:0] mag_reg [D];
    logic                 neg_reg [D];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign s_ready = (cnt_reg != (AW+1)'(D));
    assign q_valid = (cnt_reg != '0);
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;
    assign q_mag = mag_reg[rp_reg];
    assign q_neg = neg_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            neg_reg[wp_reg] <= s_value[WORD_BITS-1];
            mag_reg[wp_reg] <= s_value[WORD_BITS-1] ? (~s_value + 1'b1) : s_value;
        end
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= (wp_reg == AW'(D-1)) ? '0 : wp_reg + 1'b1;
            if (pop) rp_reg <= (rp_reg == AW'(D-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== design/itrd_back.sv =====
// Back: serial divide by radix, store digits, emit characters.
// Depends on itrd_pkg and itrd_ram.
`timescale 1ns / 1ps
module itrd_back #(
    parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [5:0]           radix,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic [WORD_BITS-1:0] q_mag,
    input  logic                 q_neg,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_out_char,
    output logic                 m_last_char
);
    localparam int AW = $clog2(WORD_BITS);
    localparam int BW = $clog2(WORD_BITS);
    localparam int CW = $clog2(WORD_BITS + 1);

    itrd_pkg::back_state_t state_reg, state_next;
    logic [WORD_BITS-1:0] quot_reg;
    logic [5:0]           rem_reg, r_eff;
    logic [BW-1:0]        bit_reg;
    logic [CW-1:0]        cnt_reg;
    logic [AW-1:0]        rd_reg;
    logic                 neg_reg;
    logic                 out_v_reg, out_last_reg, ld_pend_reg;
    logic [6:0]           out_c_reg;
    logic [6:0]           trial;
    logic [5:0]           rdata;
    logic                 we, out_free, out_load;

    always_comb begin
        priority if (radix < itrd_pkg::RADIX_MIN) r_eff = itrd_pkg::RADIX_MIN;
        else if (radix > itrd_pkg::RADIX_MAX) r_eff = itrd_pkg::RADIX_MAX;
        else r_eff = radix;
    end

    assign trial = {rem_reg, quot_reg[bit_reg]};
    assign out_free = !out_v_reg || m_ready;
    assign we = (state_reg == itrd_pkg::ST_STORE) && (cnt_reg < CW'(WORD_BITS));
    // load the output register with a sign or with a digit whose read data is ready
    assign out_load = out_free &&
                      (((state_reg == itrd_pkg::ST_SIGN) && neg_reg) ||
                       ((state_reg == itrd_pkg::ST_EMIT) && !ld_pend_reg));

    itrd_ram #(.WIDTH(6), .DEPTH(WORD_BITS)) u_store (
        .aclk(aclk), .we(we), .waddr(cnt_reg[AW-1:0]), .wdata(rem_reg),
        .raddr(rd_reg), .rdata(rdata)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itrd_pkg::ST_IDLE: if (q_valid) state_next = itrd_pkg::ST_SIGN;
            itrd_pkg::ST_SIGN: if (!neg_reg || out_free) state_next = itrd_pkg::ST_DIV;
            itrd_pkg::ST_DIV: if (bit_reg == '0) state_next = itrd_pkg::ST_STORE;
            itrd_pkg::ST_STORE:
                state_next = (quot_reg == '0) ? itrd_pkg::ST_EMIT : itrd_pkg::ST_DIV;
            itrd_pkg::ST_EMIT:
                if (!ld_pend_reg && out_free && rd_reg == '0) state_next = itrd_pkg::ST_IDLE;
            default: state_next = itrd_pkg::ST_IDLE;
        endcase
    end

    assign q_ready = (state_reg == itrd_pkg::ST_IDLE);
    assign m_valid = out_v_reg;
    assign m_out_char = out_c_reg;
    assign m_last_char = out_last_reg;

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            itrd_pkg::ST_IDLE: if (q_valid) begin
                quot_reg <= q_mag;
                neg_reg <= q_neg;
                rem_reg <= '0;
                bit_reg <= BW'(WORD_BITS - 1);
            end
            itrd_pkg::ST_DIV: begin
                if (trial >= {1'b0, r_eff}) begin
                    rem_reg <= 6'(trial - {1'b0, r_eff});
                    quot_reg[bit_reg] <= 1'b1;
                end else begin
                    rem_reg <= trial[5:0];
                    quot_reg[bit_reg] <= 1'b0;
                end
                bit_reg <= bit_reg - 1'b1;
            end
            itrd_pkg::ST_STORE: begin
                rem_reg <= '0;
                bit_reg <= BW'(WORD_BITS - 1);
            end
            default: ;
        endcase
        if (!aresetn) begin
            state_reg <= itrd_pkg::ST_IDLE;
            cnt_reg <= '0;
            rd_reg <= '0;
            out_v_reg <= 1'b0;
            ld_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) out_v_reg <= 1'b1;
            else if (m_ready) out_v_reg <= 1'b0;
            unique case (state_reg)
                itrd_pkg::ST_IDLE: cnt_reg <= '0;
                itrd_pkg::ST_SIGN: if (neg_reg && out_free) begin
                    out_c_reg <= itrd_pkg::CHAR_MINUS;
                    out_last_reg <= 1'b0;
                end
                itrd_pkg::ST_STORE: begin
                    if (cnt_reg < CW'(WORD_BITS)) cnt_reg <= cnt_reg + 1'b1;
                    if (quot_reg == '0) begin
                        rd_reg <= cnt_reg[AW-1:0];
                        ld_pend_reg <= 1'b1;
                    end
                end
                itrd_pkg::ST_EMIT: begin
                    // read data is registered, so it lands the cycle after the address; hold until output free
                    if (ld_pend_reg) ld_pend_reg <= 1'b0;
                    else if (out_free) begin
                        out_c_reg <= itrd_pkg::digit_char(rdata);
                        out_last_reg <= (rd_reg == '0);
                        if (rd_reg != '0) begin
                            rd_reg <= rd_reg - 1'b1;
                            ld_pend_reg <= 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== design/integer_to_radix_digits_unit.sv =====
// Top level of the integer to radix digits unit.
// Depends on itrd_pkg, itrd_front and itrd_back.
`timescale 1ns / 1ps
// Usage:
//   s_valid/s_ready/s_value carry one signed request per accepted value.
//   m_valid/m_ready/m_out_char/m_last_char give the string, one ASCII
//   character per transfer: '-' first for a negative value, then digits
//   most significant first, m_last_char high on the final digit.
//   cfg_we/cfg_wdata write the radix; 0 and 1 act as 2, above 36 as 36.
//   Write it only while the unit is idle.
// Structure:
//   The front queue holds two requests so a new value is taken while the
//   back end works. The back end runs a restoring shift-subtract divider,
//   one quotient bit per cycle, with a store step after each digit; the
//   digits are then read back from the digit RAM, one character per read.
// Reset and stalls:
//   aresetn (synchronous, low) empties the queue, drops any partial string
//   and sets the radix to 10. A stalled receiver holds the output register;
//   the back end waits and the front queue keeps filling until full.
module integer_to_radix_digits_unit #(
    parameter int WORD_BITS = itrd_pkg::WORD_BITS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [5:0]           cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [WORD_BITS-1:0] s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_out_char,
    output logic                 m_last_char
);
    logic [5:0]           radix_reg;
    logic                 q_valid, q_ready, q_neg;
    logic [WORD_BITS-1:0] q_mag;

    // hold the radix; a write is registered and also applies to a conversion in progress
    always_ff @(posedge aclk) begin
        if (!aresetn) radix_reg <= itrd_pkg::RADIX_RESET;
        else if (cfg_we) radix_reg <= cfg_wdata;
    end

    itrd_front #(.WORD_BITS(WORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_value(s_value),
        .q_valid(q_valid), .q_ready(q_ready), .q_mag(q_mag), .q_neg(q_neg)
    );

    itrd_back #(.WORD_BITS(WORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .radix(radix_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_mag(q_mag), .q_neg(q_neg),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_char(m_out_char), .m_last_char(m_last_char)
    );
endmodule

// ===== design/itrd_checker.sv =====
// Port-level checker for the integer to radix digits unit, with bind.
// Depends on integer_to_radix_digits_unit.
`timescale 1ns / 1ps
module itrd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_out_char,
    input logic       m_last_char
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char))
        else $error("output changed under stall");
    a_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_char == 7'd45) || (m_out_char >= 7'd48 && m_out_char <= 7'd57)
                    || (m_out_char >= 7'd65 && m_out_char <= 7'd90))
        else $error("bad character");
    a_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_char == 7'd45 |-> !m_last_char)
        else $error("minus sign flagged last");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind integer_to_radix_digits_unit itrd_checker u_itrd_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_out_char(m_out_char), .m_last_char(m_last_char)
);

// ===== verif/integer_to_radix_digits_unit_tb.sv =====
// Testbench for integer_to_radix_digits_unit: checks every character of each
// converted value against a built-in digit-string predictor.
// Depends on itrd_pkg and the integer_to_radix_digits_unit RTL.
`timescale 1ns / 1ps
module integer_to_radix_digits_unit_tb;
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } char_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_out_char;
    logic        m_last_char;

    // Requests waiting to be driven, and characters waiting to come out.
    logic [31:0] pending_values[$];
    char_t       expected_chars[$];

    logic [5:0]  radix_now = itrd_pkg::RADIX_RESET;
    int          errors = 0;
    int          chars_seen = 0;
    int          values_sent = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    logic        hold_off = 1'b0;

    integer_to_radix_digits_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Build the expected string of one value in the current base.
    task automatic predict_string(input logic [31:0] v);
        logic [31:0] mag;
        logic [5:0]  base;
        logic [5:0]  digs[$];
        logic [6:0]  c;
        base = (radix_now < itrd_pkg::RADIX_MIN) ? itrd_pkg::RADIX_MIN :
               (radix_now > itrd_pkg::RADIX_MAX) ? itrd_pkg::RADIX_MAX : radix_now;
        // unsigned negate covers the most negative value without overflow
        mag = v[31] ? (~v + 32'd1) : v;
        do begin
            digs.push_front(6'(mag % base));
            mag = mag / base;
        end while (mag != 0);
        if (v[31]) expected_chars.push_back('{itrd_pkg::CHAR_MINUS, 1'b0});
        foreach (digs[k]) begin
            c = (digs[k] < itrd_pkg::DECIMAL_DIGITS) ? 7'(7'd48 + digs[k])
                                                     : 7'(7'd65 + digs[k] - 7'd10);
            expected_chars.push_back('{c, k == digs.size() - 1});
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // Driver: hold each request until accepted, then wait a random gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            predict_string(s_value);
            values_sent++;
            s_valid <= 1'b0;
            send_gap = $urandom_range(0, 18);
            if ($urandom_range(0, 3) == 0) send_gap = 0;
        end else if (!s_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (!hold_off && pending_values.size() > 0) begin
                s_value <= pending_values.pop_front();
                s_valid <= 1'b1;
            end
        end
    end

    // Monitor: compare each accepted character; stall the receiver at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                chars_seen++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %0d", m_out_char));
                end else begin
                    if (m_out_char !== expected_chars[0].ch)
                        report_mismatch($sformatf("char %0d, want %0d",
                                        m_out_char, expected_chars[0].ch));
                    if (m_last_char !== expected_chars[0].last)
                        report_mismatch($sformatf("last flag %0b, want %0b",
                                        m_last_char, expected_chars[0].last));
                    void'(expected_chars.pop_front());
                end
                recv_gap = $urandom_range(0, 18);
                if ($urandom_range(0, 3) == 0) recv_gap = 0;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Drain: wait until every request is taken and every character is in.
    task automatic drain();
        while (pending_values.size() > 0 || s_valid || expected_chars.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_radix(input logic [5:0] r);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        radix_now = r;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] random_value();
        case ($urandom_range(0, 4))
            0: return 32'($urandom_range(0, 40));
            1: return -32'($urandom_range(1, 40));
            2: return 32'h8000_0000 + 32'($urandom_range(0, 3));
            3: return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    initial begin
        logic [5:0] radix_plan[8];
        radix_plan = '{6'd2, 6'd36, 6'd0, 6'd1, 6'd63, 6'd37, 6'd16, 6'd7};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part in the reset base: extremes, zero, signs.
        pending_values = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'd9, 32'd10, -32'd10, 32'd35,
                           32'd36, 32'hAAAA_AAAA, 32'h5555_5555};
        drain();

        // Hold the sender off with requests pending, then resume.
        hold_off = 1'b1;
        pending_values = '{32'd123456, -32'd99};
        repeat (60) @(posedge aclk);
        hold_off = 1'b0;
        drain();

        // Random part across several bases, extremes and clamped ones among them.
        foreach (radix_plan[p]) begin
            set_radix(radix_plan[p]);
            pending_values.push_back(32'h8000_0000);
            pending_values.push_back(32'h7FFF_FFFF);
            pending_values.push_back(32'd0);
            repeat (p == 0 ? 20 : 34) pending_values.push_back(random_value());
            drain();
        end
        set_radix(itrd_pkg::RADIX_RESET);
        repeat (10) pending_values.push_back(random_value());
        drain();

        $display("covered %0d values, %0d characters, bases 0 to 63 incl. clamps",
                 values_sent, chars_seen);
        if (errors == 0) begin
            $display("PASS integer_to_radix_digits_unit");
        end else begin
            $display("FAIL integer_to_radix_digits_unit");
        end
        $finish;
    end

    // Watchdog: slowest run is well under this bound.
    initial begin
        #20ms;
        $display("FAIL integer_to_radix_digits_unit");
        $finish;
    end
endmodule
